// File: hw/rtl/framed_packet_receiver_defines.svh
// Assertion macros for the framed packet receiver
`ifndef FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_DEFINES_SVH

`ifndef SYNTH
// Condition must hold at every clock edge outside reset
`define FPR_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed: lbl");
// Antecedent at one edge implies consequent at the next edge
`define FPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");
`else
`define FPR_ASSERT(lbl, cond)
`define FPR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/fpr_pkg.sv
// Shared types and constants of the framed packet receiver
package fpr_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_cmd;
    typedef logic [2:0] t_phase;

    // Parser phases
    localparam t_phase PhHunt = 3'd0;
    localparam t_phase PhType = 3'd1;
    localparam t_phase PhLen  = 3'd2;
    localparam t_phase PhCmd  = 3'd3;
    localparam t_phase PhBody = 3'd4;

    // Frame constants
    localparam t_byte MinFrameLength = 8'd5;
    localparam t_byte CmdWrite       = 8'h01;
    localparam t_byte CmdResetOk     = 8'h02;
    localparam t_byte CmdResetBad    = 8'h03;

    // Configuration register map
    localparam int    CfgIndexWidth = 8;
    typedef logic [CfgIndexWidth-1:0] t_cfg_index;
    localparam t_cfg_index CfgSyncValue = 8'd0;
    localparam t_cfg_index CfgTypeValue = 8'd1;

    // Register reset values
    localparam t_byte SyncReset = 8'h55;
    localparam t_byte TypeReset = 8'h0B;

endpackage

// File: hw/rtl/fpr_if.sv
// Channel interfaces of the framed packet receiver

// Received byte channel
interface fpr_byte_if import fpr_pkg::*;;
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel: payload bytes and frame-end words
interface fpr_result_if import fpr_pkg::*;;
    logic  valid;
    logic  ready;
    logic  frame_end;
    t_byte payload_byte;
    t_byte payload_index;
    t_cmd  command_code;
    t_byte payload_length;
    logic  checksum_ok;

    modport source (output valid, output frame_end, output payload_byte,
                    output payload_index, output command_code,
                    output payload_length, output checksum_ok, input ready);
    modport sink   (input valid, input frame_end, input payload_byte,
                    input payload_index, input command_code,
                    input payload_length, input checksum_ok, output ready);
endinterface

// Configuration write channel
interface fpr_cfg_if import fpr_pkg::*;;
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_byte      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/framed_packet_receiver.sv
// Framed packet receiver: sync/type/length/command parser with additive checksum
//
// Channels: i_rx carries one received byte per word; o_res carries one result
// word, either a payload byte with its index or a frame-end word with the
// command, payload length and checksum flag; i_cfg writes the sync byte
// (index 0) and the type byte (index 1), always ready.
// Each accepted byte is parsed in the cycle it is taken; a result appears in
// the output register on the next cycle. One byte per cycle is accepted while
// the output register is empty or being taken.
// i_rx.ready stays high while the output register is empty or being taken, so
// a stalled receiver holds the pending result and stops input only once the
// output register is full and not taken.
// Reset (i_rst_n low, synchronous) returns the parser to hunting for the sync
// byte, empties the output register and restores sync 0x55 and type 0x0B.
// Frames: sync, type, length (5..255), command (1..3), length-5 payload
// bytes, checksum; a mismatch in the header returns to hunting.
module framed_packet_receiver import fpr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fpr_byte_if.sink          i_rx,
    fpr_result_if.source      o_res,
    fpr_cfg_if.sink           i_cfg
);

`include "framed_packet_receiver_defines.svh"

    // Configuration registers
    t_byte r_sync_value;
    t_byte r_type_value;

    // Parser state
    t_phase r_phase,  n_phase;
    t_byte  r_plen,   n_plen;
    t_byte  r_sum,    n_sum;
    t_byte  r_count,  n_count;
    t_cmd   r_cmd,    n_cmd;

    // Output register
    logic   r_out_valid, n_out_valid;
    logic   r_frame_end, n_frame_end;
    t_byte  r_pay_byte,  n_pay_byte;
    t_byte  r_pay_index, n_pay_index;
    t_cmd   r_out_cmd,   n_out_cmd;
    t_byte  r_out_len,   n_out_len;
    logic   r_ok,        n_ok;

    logic   in_acc;
    t_byte  sum_b;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = !r_out_valid || o_res.ready;
    assign in_acc      = i_rx.valid && i_rx.ready;
    assign sum_b       = r_sum + i_rx.rx_byte;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= SyncReset;
            r_type_value <= TypeReset;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CfgSyncValue: r_sync_value <= i_cfg.data;
                CfgTypeValue: r_type_value <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Parse step: one byte into state and output register
    always_comb begin
        n_phase     = r_phase;
        n_plen      = r_plen;
        n_sum       = r_sum;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && !o_res.ready;
        n_frame_end = r_frame_end;
        n_pay_byte  = r_pay_byte;
        n_pay_index = r_pay_index;
        n_out_cmd   = r_out_cmd;
        n_out_len   = r_out_len;
        n_ok        = r_ok;
        if (in_acc) begin
            unique case (r_phase)
                PhType: begin
                    if (i_rx.rx_byte == r_type_value) begin
                        n_sum   = sum_b;
                        n_phase = PhLen;
                    end else begin
                        n_phase = PhHunt;
                    end
                end
                PhLen: begin
                    if (i_rx.rx_byte >= MinFrameLength) begin
                        n_plen  = i_rx.rx_byte - MinFrameLength;
                        n_sum   = sum_b;
                        n_phase = PhCmd;
                    end else begin
                        n_phase = PhHunt;
                    end
                end
                PhCmd: begin
                    case (i_rx.rx_byte) inside
                        CmdWrite, CmdResetOk, CmdResetBad: begin
                            n_cmd   = i_rx.rx_byte[1:0];
                            n_sum   = sum_b;
                            n_count = '0;
                            n_phase = PhBody;
                        end
                        default: n_phase = PhHunt;
                    endcase
                end
                PhBody: begin
                    n_sum       = sum_b;
                    n_out_valid = 1'b1;
                    n_out_cmd   = r_cmd;
                    n_out_len   = r_plen;
                    if (r_count < r_plen) begin
                        // payload byte
                        n_frame_end = 1'b0;
                        n_pay_byte  = i_rx.rx_byte;
                        n_pay_index = r_count;
                        n_ok        = 1'b0;
                        n_count     = r_count + 8'd1;
                    end else begin
                        // checksum byte closes the frame
                        n_frame_end = 1'b1;
                        n_pay_byte  = '0;
                        n_pay_index = '0;
                        n_ok        = (sum_b == '0);
                        n_count     = '0;
                        n_phase     = PhHunt;
                    end
                end
                default: begin
                    // hunting, and unused phase codes
                    if (i_rx.rx_byte == r_sync_value) begin
                        n_sum   = i_rx.rx_byte;
                        n_count = '0;
                        n_phase = PhType;
                    end else begin
                        n_phase = PhHunt;
                    end
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PhHunt;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // Frame and result payload
    always_ff @(posedge i_clk) begin
        r_plen      <= n_plen;
        r_sum       <= n_sum;
        r_count     <= n_count;
        r_cmd       <= n_cmd;
        r_frame_end <= n_frame_end;
        r_pay_byte  <= n_pay_byte;
        r_pay_index <= n_pay_index;
        r_out_cmd   <= n_out_cmd;
        r_out_len   <= n_out_len;
        r_ok        <= n_ok;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.frame_end      = r_frame_end;
    assign o_res.payload_byte   = r_pay_byte;
    assign o_res.payload_index  = r_pay_index;
    assign o_res.command_code   = r_out_cmd;
    assign o_res.payload_length = r_out_len;
    assign o_res.checksum_ok    = r_ok;

    // Checks
    `FPR_ASSERT(a_end_word_zero, !(r_out_valid && r_frame_end) || (r_pay_byte == '0 && r_pay_index == '0))
    `FPR_ASSERT(a_index_in_frame, !(r_out_valid && !r_frame_end) || (r_pay_index < r_out_len && !r_ok))
    `FPR_ASSERT(a_count_bounded, (r_phase != PhBody) || (r_count <= r_plen))
    `FPR_ASSERT_NEXT(a_hunt_exit, in_acc && r_phase == PhHunt, r_phase == PhHunt || r_phase == PhType)

endmodule

// File: dv/tb_framed_packet_receiver.sv
// Self-checking testbench for the framed packet receiver
module tb_framed_packet_receiver;
    timeunit 1ns;
    timeprecision 1ps;
    import fpr_pkg::*;

    // One result word as seen on the output channel
    typedef struct packed {
        logic  frame_end;
        t_byte payload_byte;
        t_byte payload_index;
        t_cmd  command_code;
        t_byte payload_length;
        logic  checksum_ok;
    } t_rx_result;

    typedef enum int {IdleNone, IdleSparse, IdleHeavy} t_idle_mode;

    // Register indexes outside the map, written to show they are ignored
    localparam t_cfg_index CfgUnmapped = 8'd2;
    localparam t_cfg_index CfgTopIndex = 8'hFF;
    localparam int         NumSettings = 6;
    // random traffic bytes after the directed frames
    localparam int         ByteBudget  = 520;

    logic i_clk;
    logic i_rst_n;

    fpr_byte_if   rx_ch ();
    fpr_result_if res_ch ();
    fpr_cfg_if    cfg_ch ();

    framed_packet_receiver u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Parser shadow state and register copies
    t_phase pr_phase  = PhHunt;
    t_byte  pr_length = '0;
    t_byte  pr_sum    = '0;
    t_byte  pr_count  = '0;
    t_cmd   pr_cmd    = '0;
    t_byte  cfg_sync  = SyncReset;
    t_byte  cfg_type  = TypeReset;

    t_byte      rx_stream[$];
    t_rx_result expected_results[$];

    t_idle_mode rx_idle_mode  = IdleNone;
    t_idle_mode res_idle_mode = IdleNone;
    int rx_gap_left     = 0;
    int res_stall_left  = 0;
    int bytes_pushed    = 0;
    int bytes_accepted  = 0;
    int random_base     = 0;
    int payload_words   = 0;
    int frame_ends      = 0;
    int good_frames     = 0;
    int mismatches      = 0;
    t_rx_result seen_word, want_word;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycles to hold off before the next word, by idle mode
    function automatic int draw_wait(input t_idle_mode mode);
        case (mode)
            IdleSparse: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
            IdleHeavy:  return $urandom_range(0, 12);
            default:    return 0;
        endcase
    endfunction

    // Advance the shadow parser by one byte; queue the result word it causes
    task automatic parse_byte(input t_byte b);
        t_byte      plen;
        t_rx_result w;
        case (pr_phase)
            PhType: begin
                if (b == cfg_type) begin
                    pr_sum   = pr_sum + b;
                    pr_phase = PhLen;
                end else begin
                    pr_phase = PhHunt;
                end
            end
            PhLen: begin
                if (b >= MinFrameLength) begin
                    pr_length = b;
                    pr_sum    = pr_sum + b;
                    pr_phase  = PhCmd;
                end else begin
                    pr_phase = PhHunt;
                end
            end
            PhCmd: begin
                if (b == CmdWrite || b == CmdResetOk || b == CmdResetBad) begin
                    pr_cmd   = b[1:0];
                    pr_sum   = pr_sum + b;
                    pr_count = '0;
                    pr_phase = PhBody;
                end else begin
                    pr_phase = PhHunt;
                end
            end
            PhBody: begin
                plen   = pr_length - MinFrameLength;
                pr_sum = pr_sum + b;
                w.command_code   = pr_cmd;
                w.payload_length = plen;
                if (pr_count < plen) begin
                    w.frame_end     = 1'b0;
                    w.payload_byte  = b;
                    w.payload_index = pr_count;
                    w.checksum_ok   = 1'b0;
                    pr_count        = pr_count + 8'd1;
                end else begin
                    w.frame_end     = 1'b1;
                    w.payload_byte  = '0;
                    w.payload_index = '0;
                    w.checksum_ok   = (pr_sum == 8'd0);
                    pr_count        = '0;
                    pr_phase        = PhHunt;
                end
                expected_results.push_back(w);
            end
            default: begin
                if (b == cfg_sync) begin
                    pr_sum   = b;
                    pr_count = '0;
                    pr_phase = PhType;
                end else begin
                    pr_phase = PhHunt;
                end
            end
        endcase
    endtask

    // Byte driver: one word at a time from the pending stream
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_ch.valid && rx_ch.ready) begin
                parse_byte(rx_ch.rx_byte);
                bytes_accepted++;
            end
            if (!rx_ch.valid || rx_ch.ready) begin
                if (rx_gap_left > 0) begin
                    rx_gap_left--;
                    rx_ch.valid <= 1'b0;
                end else if (rx_stream.size() > 0) begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= rx_stream.pop_front();
                    rx_gap_left = draw_wait(rx_idle_mode);
                end else begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    function automatic int field_differs(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Result monitor: compare each taken word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                seen_word = '{res_ch.frame_end, res_ch.payload_byte, res_ch.payload_index,
                              res_ch.command_code, res_ch.payload_length,
                              res_ch.checksum_ok};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none actual %p",
                             $time, seen_word);
                    mismatches++;
                end else begin
                    want_word = expected_results.pop_front();
                    if (field_differs("frame_end", want_word.frame_end, seen_word.frame_end)
                        + field_differs("payload_byte", want_word.payload_byte,
                                        seen_word.payload_byte)
                        + field_differs("payload_index", want_word.payload_index,
                                        seen_word.payload_index)
                        + field_differs("command_code", want_word.command_code,
                                        seen_word.command_code)
                        + field_differs("payload_length", want_word.payload_length,
                                        seen_word.payload_length)
                        + field_differs("checksum_ok", want_word.checksum_ok,
                                        seen_word.checksum_ok) != 0)
                        mismatches++;
                    if (seen_word.frame_end) begin
                        frame_ends++;
                        if (seen_word.checksum_ok) good_frames++;
                    end else begin
                        payload_words++;
                    end
                end
                res_stall_left = draw_wait(res_idle_mode);
            end
            if (res_stall_left > 0) begin
                res_stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input t_byte b);
        rx_stream.push_back(b);
        bytes_pushed++;
    endtask

    // Register write over the config channel; shadow copy follows the handshake
    task automatic write_reg(input t_cfg_index idx, input t_byte val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == CfgSyncValue) cfg_sync = val;
        else if (idx == CfgTypeValue) cfg_type = val;
        cfg_ch.valid <= 1'b0;
    endtask

    // Whole frame, or only its first 'keep' payload bytes when keep >= 0
    task automatic add_frame(input t_byte len, input t_byte cmd, input bit good_sum,
                             input int keep, input bit extremes);
        t_byte sum;
        t_byte b;
        int    plen;
        plen = len - MinFrameLength;
        push_byte(cfg_sync);
        push_byte(cfg_type);
        push_byte(len);
        push_byte(cmd);
        sum = cfg_sync + cfg_type + len + cmd;
        for (int i = 0; i < plen; i++) begin
            if (keep >= 0 && i >= keep) return;
            b = extremes ? ((i % 2 == 0) ? 8'hFF : 8'h00) : t_byte'($urandom);
            push_byte(b);
            sum = sum + b;
        end
        push_byte(good_sum ? t_byte'(8'd0 - sum) : t_byte'(8'd1 - sum));
    endtask

    task automatic add_random_packet();
        int    r;
        t_byte b;
        t_byte len;
        t_byte cmd;
        r   = $urandom_range(0, 99);
        cmd = t_byte'($urandom_range(1, 3));
        case ($urandom_range(0, 32))
            0:       len = t_byte'($urandom_range(200, 255));
            1, 2, 3: len = t_byte'($urandom_range(21, 60));
            default: len = t_byte'($urandom_range(5, 20));
        endcase
        if (r < 72) begin
            add_frame(len, cmd, $urandom_range(0, 5) != 0, -1, 1'b0);
        end else if (r < 80) begin
            // line noise, now and then a stray sync byte
            repeat ($urandom_range(1, 6))
                push_byte(($urandom_range(0, 3) == 0) ? cfg_sync : t_byte'($urandom));
        end else if (r < 90) begin
            // header broken at type, length or command
            push_byte(cfg_sync);
            case ($urandom_range(0, 2))
                0: begin
                    do b = t_byte'($urandom); while (b == cfg_type);
                    push_byte(b);
                end
                1: begin
                    push_byte(cfg_type);
                    push_byte(t_byte'($urandom_range(0, 4)));
                end
                default: begin
                    push_byte(cfg_type);
                    push_byte(len);
                    do b = ($urandom_range(0, 1) != 0) ? 8'h00 : t_byte'($urandom);
                    while (b inside {CmdWrite, CmdResetOk, CmdResetBad});
                    push_byte(b);
                end
            endcase
        end else begin
            // frame cut short; following bytes land in its body
            add_frame(len, cmd, 1'b1, $urandom_range(0, len - MinFrameLength), 1'b0);
        end
    endtask

    // Let every pushed byte and every expected word pass, then settle
    task automatic wait_drained();
        while (bytes_accepted != bytes_pushed || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Stimulus: directed frames, then random traffic under several settings
    initial begin
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // minimum length: checksum follows the command directly
        add_frame(MinFrameLength, CmdWrite, 1'b1, -1, 1'b0);
        add_frame(8'd7, CmdResetBad, 1'b1, -1, 1'b1);
        add_frame(8'd6, CmdResetOk, 1'b0, -1, 1'b0);
        // sync in the type slot is not taken as a new sync
        push_byte(cfg_sync);
        push_byte(cfg_sync);
        push_byte(cfg_type);
        // length below minimum, then command zero
        push_byte(cfg_sync);
        push_byte(cfg_type);
        push_byte(8'd4);
        push_byte(cfg_sync);
        push_byte(cfg_type);
        push_byte(MinFrameLength);
        push_byte(8'h00);
        // largest frame: payload indexes up to 249
        add_frame(8'hFF, CmdWrite, 1'b1, -1, 1'b0);

        // each setting gets its own share of the random traffic
        random_base = bytes_pushed;
        for (int s = 0; s < NumSettings; s++) begin
            if (s > 0) begin
                wait_drained();
                case (s)
                    1: begin
                        write_reg(CfgSyncValue, 8'h00);
                        write_reg(CfgTypeValue, 8'hFF);
                        write_reg(CfgUnmapped, 8'h55);
                    end
                    2: begin
                        write_reg(CfgSyncValue, 8'hFF);
                        write_reg(CfgTypeValue, 8'h00);
                        write_reg(CfgTopIndex, 8'hA5);
                    end
                    3: begin
                        // sync and type equal
                        write_reg(CfgSyncValue, 8'h3C);
                        write_reg(CfgTypeValue, 8'h3C);
                    end
                    4: begin
                        write_reg(CfgSyncValue, t_byte'($urandom));
                        write_reg(CfgTypeValue, t_byte'($urandom));
                    end
                    default: begin
                        write_reg(CfgSyncValue, SyncReset);
                        write_reg(CfgTypeValue, TypeReset);
                    end
                endcase
            end
            rx_idle_mode  = t_idle_mode'(s % 3);
            res_idle_mode = t_idle_mode'((s + 1) % 3);
            while (bytes_pushed < random_base + (s + 1) * ByteBudget / NumSettings)
                add_random_packet();
        end
        wait_drained();

        $display("Drove %0d bytes under %0d register settings with mixed stalls.",
                 bytes_accepted, NumSettings);
        $display("Checked %0d payload words and %0d frame ends, %0d with a good checksum.",
                 payload_words, frame_ends, good_frames);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("%0t: timed out with %0d bytes pending and %0d words expected",
                 $time, bytes_pushed - bytes_accepted, expected_results.size());
        $display("FAIL");
        $finish;
    end

endmodule
